FILE: sv/cdrom_raw_sector_checker_defines.svh
// ---------------------------------------------------------------------------
// cdrom_raw_sector_checker_defines
// assertion macros used by the sector checker controller
// ---------------------------------------------------------------------------
`ifndef CDROM_RAW_SECTOR_CHECKER_DEFINES_SVH
`define CDROM_RAW_SECTOR_CHECKER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define CRSC_ASSERT_NOW(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("sector checker assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define CRSC_ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("sector checker assertion failed");

`endif

FILE: sv/crsc_pkg.sv
// ---------------------------------------------------------------------------
// crsc_pkg
// constants, control types and helper functions of the sector checker
// ---------------------------------------------------------------------------
package crsc_pkg;

	localparam int SECTOR_BYTES = 2352;
	localparam logic [11:0] POS_LAST = 12'd2351;

	localparam logic [11:0] POS_MODE1_EDC  = 12'd2064;
	localparam logic [11:0] POS_FORM1_EDC  = 12'd2072;
	localparam logic [11:0] POS_FORM2_EDC  = 12'd2348;
	localparam logic [11:0] POS_MODE1_SNAP = 12'd2063;
	localparam logic [11:0] POS_FORM1_SNAP = 12'd2071;
	localparam logic [11:0] POS_FORM2_SNAP = 12'd2347;
	localparam logic [11:0] POS_SUBHDR     = 12'd16;
	localparam logic [11:0] POS_DATA       = 12'd12;

	// p parity: 86 majors of 24, q parity: 52 majors of 43
	localparam logic [6:0]  P_MAJORS = 7'd86;
	localparam logic [5:0]  P_MINORS = 6'd24;
	localparam logic [11:0] P_MULT   = 12'd2;
	localparam logic [11:0] P_INC    = 12'd86;
	localparam logic [11:0] P_SIZE   = 12'd2064;
	localparam logic [11:0] P_CHECK  = 12'd2076;
	localparam logic [6:0]  Q_MAJORS = 7'd52;
	localparam logic [5:0]  Q_MINORS = 6'd43;
	localparam logic [11:0] Q_MULT   = 12'd86;
	localparam logic [11:0] Q_INC    = 12'd88;
	localparam logic [11:0] Q_SIZE   = 12'd2236;
	localparam logic [11:0] Q_CHECK  = 12'd2248;

	localparam logic [31:0] EDC_POLY = 32'hD8018001;
	localparam logic [8:0]  GF_POLY  = 9'h11D;
	localparam logic [7:0]  GF_INV3  = 8'hF4;

	localparam logic [2:0] MODE_UNKNOWN  = 3'd0;
	localparam logic [2:0] MODE_MODE1    = 3'd1;
	localparam logic [2:0] MODE_FORMLESS = 3'd2;
	localparam logic [2:0] MODE_FORM1    = 3'd3;
	localparam logic [2:0] MODE_FORM2    = 3'd4;

	typedef struct packed {
		logic load;
		logic par_start;
		logic par_run;
		logic finish;
	} crsc_cmd_t;

	typedef struct packed {
		logic last_byte;
		logic need_ecc;
		logic issue_done;
	} crsc_status_t;

	function automatic logic [31:0] edc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? EDC_POLY : 32'd0);
		end
		return c;
	endfunction

	function automatic logic [7:0] gf_dbl(input logic [7:0] x);
		logic [8:0] j;
		j = {x, 1'b0};
		if (j[8]) begin
			j = j ^ GF_POLY;
		end
		return j[7:0];
	endfunction

	// divide by 3, as a product with the inverse of 3
	function automatic logic [7:0] gf_div3(input logic [7:0] y);
		logic [7:0] acc;
		logic [7:0] sh;
		acc = 8'd0;
		sh = y;
		for (int k = 0; k < 8; k++) begin
			if (GF_INV3[k]) begin
				acc = acc ^ sh;
			end
			sh = gf_dbl(sh);
		end
		return acc;
	endfunction

	function automatic logic bcd_ok(input logic [7:0] v);
		return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
	endfunction

	function automatic logic [6:0] bcd_val(input logic [7:0] v);
		return 7'({3'd0, v[7:4]} * 7'd10 + {3'd0, v[3:0]});
	endfunction

endpackage

FILE: sv/cdrom_raw_sector_checker.sv
// ---------------------------------------------------------------------------
// cdrom_raw_sector_checker
// checks one raw cd-rom sector (sync, header, mode, edc, p/q parity)
// ---------------------------------------------------------------------------
// channel   signals                          transaction
// input     start, busy, data_byte,          start high and busy low at clk edge
//           expected_lba
// verdict   done, sector_valid .. ecc_ok     done high for one cycle
//
// bytes 0..2350 are loaded while busy stays low.
// after byte 2351 busy goes high; when no parity applies only the finish state
// follows, otherwise 4300 source reads and 276 check byte reads, one store read
// per cycle through the single read port, then the drain and finish states.
// done comes in the first cycle with busy low again.
// arst_n clears the controller, byte position and edc state.
// the verdict receiver cannot stall.
// ---------------------------------------------------------------------------
module cdrom_raw_sector_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         data_byte,
	input  logic [18:0]        expected_lba,
	output logic               done,
	output logic               sector_valid,
	output logic               sync_ok,
	output logic               address_ok,
	output logic signed [20:0] address_delta,
	output logic [2:0]         sector_mode,
	output logic               subheader_ok,
	output logic               edc_present,
	output logic               edc_ok,
	output logic               ecc_present,
	output logic               ecc_ok
);
	import crsc_pkg::*;

	crsc_cmd_t    cmd;
	crsc_status_t st;

	crsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	crsc_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.data_byte     (data_byte),
		.expected_lba  (expected_lba),
		.sector_valid  (sector_valid),
		.sync_ok       (sync_ok),
		.address_ok    (address_ok),
		.address_delta (address_delta),
		.sector_mode   (sector_mode),
		.subheader_ok  (subheader_ok),
		.edc_present   (edc_present),
		.edc_ok        (edc_ok),
		.ecc_present   (ecc_present),
		.ecc_ok        (ecc_ok)
	);

endmodule

FILE: sv/crsc_ctrl.sv
// ---------------------------------------------------------------------------
// crsc_ctrl
// controller: byte loading, parity sweep sequencing and verdict strobe
// ---------------------------------------------------------------------------
`include "cdrom_raw_sector_checker_defines.svh"

module crsc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  crsc_pkg::crsc_status_t st,
	output crsc_pkg::crsc_cmd_t    cmd,
	output logic                   busy,
	output logic                   done
);
	import crsc_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_PAR    = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
				if (start && st.last_byte) begin
					if (st.need_ecc) begin
						cmd.par_start = 1'b1;
						state_d = ST_PAR;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_PAR: begin
				cmd.par_run = 1'b1;
				if (st.issue_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= cmd.finish;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	`CRSC_ASSERT_NOW(a_done_idle, done_q, state_q == ST_IDLE)
	`CRSC_ASSERT_NEXT(a_drain_finish, state_q == ST_DRAIN, state_q == ST_FINISH)
	`CRSC_ASSERT_NEXT(a_last_busy, (state_q == ST_IDLE) && start && st.last_byte, busy)
	`CRSC_ASSERT_NEXT(a_finish_done, state_q == ST_FINISH, done_q)

endmodule

FILE: sv/crsc_dpath.sv
// ---------------------------------------------------------------------------
// crsc_dpath
// datapath: sector store, edc, header capture, p/q parity and verdict
// ---------------------------------------------------------------------------
module crsc_dpath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  crsc_pkg::crsc_cmd_t    cmd,
	output crsc_pkg::crsc_status_t st,
	input  logic [7:0]             data_byte,
	input  logic [18:0]            expected_lba,
	output logic                   sector_valid,
	output logic                   sync_ok,
	output logic                   address_ok,
	output logic signed [20:0]     address_delta,
	output logic [2:0]             sector_mode,
	output logic                   subheader_ok,
	output logic                   edc_present,
	output logic                   edc_ok,
	output logic                   ecc_present,
	output logic                   ecc_ok
);
	import crsc_pkg::*;

	localparam logic [1:0] KIND_SRC = 2'd0;
	localparam logic [1:0] KIND_A   = 2'd1;
	localparam logic [1:0] KIND_B   = 2'd2;

	logic [7:0]  mem [SECTOR_BYTES];
	logic [11:0] pos_q;
	logic [7:0]  hdr_q [24];
	logic [31:0] edc_start_q, edc_sub_q;
	logic [31:0] snap_m1_q, snap_f1_q, snap_f2_q;
	logic [31:0] st_m1_q, st_f1_q, st_f2_q;
	logic [18:0] lba_q;

	// parity sweep
	logic        phase_q;
	logic [6:0]  m_q;
	logic [5:0]  n_q;
	logic [1:0]  kind_q;
	logic [11:0] base_q, idx_q;
	logic [11:0] rd_addr;
	logic        rd_zero;
	logic [7:0]  rd_s1;
	logic        tag_vld_s1, tag_zero_s1;
	logic [1:0]  tag_kind_s1;
	logic [7:0]  a_q, b_q, afin_q;
	logic        err_q;
	logic        zero_hdr_q;

	logic [6:0]  majors;
	logic [5:0]  minors;
	logic [11:0] mult, inc, size, chk;
	logic [12:0] idx_sum;
	logic [11:0] idx_next;

	// classification
	logic        sync_w, bcd_w, form2_w, mb1_w, mb2_w;
	logic [2:0]  diff_w;
	logic [19:0] addr_sum;
	logic signed [20:0] delta_w;

	always_comb begin
		majors = phase_q ? Q_MAJORS : P_MAJORS;
		minors = phase_q ? Q_MINORS : P_MINORS;
		mult   = phase_q ? Q_MULT : P_MULT;
		inc    = phase_q ? Q_INC : P_INC;
		size   = phase_q ? Q_SIZE : P_SIZE;
		chk    = phase_q ? Q_CHECK : P_CHECK;
		idx_sum = {1'b0, idx_q} + {1'b0, inc};
		idx_next = (idx_sum >= {1'b0, size}) ? 12'(idx_sum - {1'b0, size}) : idx_sum[11:0];
		rd_zero = 1'b0;
		case (kind_q)
			KIND_SRC: begin
				rd_addr = idx_q + POS_DATA;
				rd_zero = zero_hdr_q && (idx_q < 12'd4);
			end
			KIND_A:  rd_addr = chk + {5'd0, m_q};
			KIND_B:  rd_addr = chk + {5'd0, m_q} + {5'd0, majors};
			default: rd_addr = chk;
		endcase
	end

	always_comb begin
		sync_w = (hdr_q[0] == 8'h00) && (hdr_q[11] == 8'h00);
		for (int i = 1; i < 11; i++) begin
			if (hdr_q[i] != 8'hFF) begin
				sync_w = 1'b0;
			end
		end
		bcd_w = bcd_ok(hdr_q[12]) && bcd_ok(hdr_q[13]) && bcd_ok(hdr_q[14]);
		addr_sum = 20'(bcd_val(hdr_q[12]) * 20'd4500) + 20'(bcd_val(hdr_q[13]) * 20'd75)
			+ {13'd0, bcd_val(hdr_q[14])};
		delta_w = $signed({1'b0, addr_sum}) - 21'sd150 - $signed({2'b00, lba_q});
		mb1_w = (hdr_q[15] == 8'h01);
		mb2_w = (hdr_q[15] == 8'h02);
		form2_w = hdr_q[18][5];
		diff_w = 3'd0;
		for (int i = 0; i < 4; i++) begin
			if (hdr_q[16 + i] != hdr_q[20 + i]) begin
				diff_w = diff_w + 3'd1;
			end
		end
	end

	assign st.last_byte = (pos_q == POS_LAST);
	assign st.need_ecc = sync_w && (mb1_w || (mb2_w && (diff_w == 3'd0) && !form2_w));
	assign st.issue_done = cmd.par_run && phase_q && (kind_q == KIND_B)
		&& (m_q == Q_MAJORS - 7'd1);

	// sector store
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[pos_q] <= data_byte;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1 <= mem[rd_addr];
		tag_zero_s1 <= rd_zero;
		tag_kind_s1 <= kind_q;
	end

	// header bytes, stored edc words, expected address
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (pos_q < 12'd24) begin
				hdr_q[pos_q[4:0]] <= data_byte;
			end
			if (pos_q >= POS_MODE1_EDC && pos_q < POS_MODE1_EDC + 12'd4) begin
				st_m1_q <= {data_byte, st_m1_q[31:8]};
			end
			if (pos_q >= POS_FORM1_EDC && pos_q < POS_FORM1_EDC + 12'd4) begin
				st_f1_q <= {data_byte, st_f1_q[31:8]};
			end
			if (pos_q >= POS_FORM2_EDC) begin
				st_f2_q <= {data_byte, st_f2_q[31:8]};
			end
			if (pos_q == POS_LAST) begin
				lba_q <= expected_lba;
			end
		end
	end

	// byte position and edc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			edc_start_q <= '0;
			edc_sub_q <= '0;
			snap_m1_q <= '0;
			snap_f1_q <= '0;
			snap_f2_q <= '0;
		end else if (cmd.finish) begin
			edc_start_q <= '0;
			edc_sub_q <= '0;
			snap_m1_q <= '0;
			snap_f1_q <= '0;
			snap_f2_q <= '0;
		end else if (cmd.load) begin
			pos_q <= (pos_q == POS_LAST) ? 12'd0 : pos_q + 12'd1;
			if (pos_q < POS_MODE1_EDC) begin
				edc_start_q <= edc_byte(edc_start_q, data_byte);
				if (pos_q == POS_MODE1_SNAP) begin
					snap_m1_q <= edc_byte(edc_start_q, data_byte);
				end
			end
			if (pos_q >= POS_SUBHDR && pos_q < POS_FORM2_EDC) begin
				edc_sub_q <= edc_byte(edc_sub_q, data_byte);
				if (pos_q == POS_FORM1_SNAP) begin
					snap_f1_q <= edc_byte(edc_sub_q, data_byte);
				end
				if (pos_q == POS_FORM2_SNAP) begin
					snap_f2_q <= edc_byte(edc_sub_q, data_byte);
				end
			end
		end
	end

	// parity address sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			m_q <= '0;
			n_q <= '0;
			kind_q <= KIND_SRC;
			base_q <= '0;
			idx_q <= '0;
			zero_hdr_q <= 1'b0;
			tag_vld_s1 <= 1'b0;
		end else begin
			tag_vld_s1 <= cmd.par_run;
			if (cmd.par_start) begin
				phase_q <= 1'b0;
				m_q <= '0;
				n_q <= '0;
				kind_q <= KIND_SRC;
				base_q <= '0;
				idx_q <= '0;
				zero_hdr_q <= mb2_w;
			end else if (cmd.par_run) begin
				case (kind_q)
					KIND_SRC: begin
						idx_q <= idx_next;
						n_q <= n_q + 6'd1;
						if (n_q == minors - 6'd1) begin
							kind_q <= KIND_A;
						end
					end
					KIND_A: begin
						kind_q <= KIND_B;
					end
					default: begin
						kind_q <= KIND_SRC;
						n_q <= '0;
						if (m_q == majors - 7'd1) begin
							phase_q <= 1'b1;
							m_q <= '0;
							base_q <= '0;
							idx_q <= '0;
						end else begin
							m_q <= m_q + 7'd1;
							if (m_q[0]) begin
								base_q <= base_q + mult;
								idx_q <= base_q + mult;
							end else begin
								idx_q <= base_q + 12'd1;
							end
						end
					end
				endcase
			end
		end
	end

	// parity accumulation and compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			err_q <= 1'b0;
		end else if (cmd.par_start) begin
			a_q <= '0;
			b_q <= '0;
			err_q <= 1'b0;
		end else if (tag_vld_s1) begin
			case (tag_kind_s1)
				KIND_SRC: begin
					a_q <= gf_dbl(a_q ^ (tag_zero_s1 ? 8'd0 : rd_s1));
					b_q <= b_q ^ (tag_zero_s1 ? 8'd0 : rd_s1);
				end
				KIND_A: begin
					if (rd_s1 != gf_div3(gf_dbl(a_q) ^ b_q)) begin
						err_q <= 1'b1;
					end
				end
				default: begin
					if (rd_s1 != (afin_q ^ b_q)) begin
						err_q <= 1'b1;
					end
					a_q <= '0;
					b_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		afin_q <= gf_div3(gf_dbl(a_q) ^ b_q);
	end

	// verdict register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			sector_valid <= 1'b0;
			sync_ok <= sync_w;
			address_ok <= 1'b0;
			address_delta <= '0;
			sector_mode <= MODE_UNKNOWN;
			subheader_ok <= 1'b1;
			edc_present <= 1'b0;
			edc_ok <= 1'b0;
			ecc_present <= 1'b0;
			ecc_ok <= 1'b0;
			if (sync_w) begin
				if (bcd_w) begin
					address_delta <= delta_w;
					address_ok <= (delta_w == 21'sd0);
				end
				if (mb1_w) begin
					sector_mode <= MODE_MODE1;
					edc_present <= 1'b1;
					edc_ok <= (snap_m1_q == st_m1_q);
					ecc_present <= 1'b1;
					ecc_ok <= !err_q;
					sector_valid <= bcd_w && (delta_w == 21'sd0) && (snap_m1_q == st_m1_q)
						&& !err_q;
				end else if (mb2_w) begin
					if (diff_w == 3'd1) begin
						subheader_ok <= 1'b0;
						sector_mode <= form2_w ? MODE_FORM2 : MODE_FORM1;
					end else if (diff_w > 3'd1) begin
						sector_mode <= MODE_FORMLESS;
						sector_valid <= bcd_w && (delta_w == 21'sd0);
					end else if (form2_w) begin
						sector_mode <= MODE_FORM2;
						edc_present <= 1'b1;
						edc_ok <= (snap_f2_q == st_f2_q);
						ecc_ok <= 1'b1;
						sector_valid <= bcd_w && (delta_w == 21'sd0) && (snap_f2_q == st_f2_q);
					end else begin
						sector_mode <= MODE_FORM1;
						edc_present <= 1'b1;
						edc_ok <= (snap_f1_q == st_f1_q);
						ecc_present <= 1'b1;
						ecc_ok <= !err_q;
						sector_valid <= bcd_w && (delta_w == 21'sd0) && (snap_f1_q == st_f1_q)
							&& !err_q;
					end
				end
			end
		end
	end

endmodule
